// ----- sv/ugcs_pkg.sv -----
// shared types, constants and helper functions of the uniform grid cell sort block
package ugcs_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int MAX_CELLS     = 4096;

    localparam int PID_W   = 10;
    localparam int CELL_W  = 12;
    localparam int CNT_W   = 11;
    localparam int DIM_W   = 13;
    localparam int OFF_DEPTH = MAX_CELLS + 1;
    localparam int OFF_AW  = 13;
    localparam int FIX_W   = 31;
    localparam int POS_W   = 32;
    localparam int DIV_STEPS = FIX_W;
    localparam int PROD_W  = CELL_W + DIM_W;

    localparam logic [CNT_W-1:0] MAX_PART_CNT = CNT_W'(MAX_PARTICLES);
    localparam logic [DIM_W-1:0] MAX_DIM      = DIM_W'(4096);
    localparam logic [DIM_W-1:0] MAX_NC       = DIM_W'(MAX_CELLS);

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_SORT  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_QUERY = 2'd3
    } kind_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NOSORT = 2'd2;

    localparam logic [2:0] REG_CELL_SIZE = 3'd0;
    localparam logic [2:0] REG_BOX_X     = 3'd1;
    localparam logic [2:0] REG_BOX_Y     = 3'd2;
    localparam logic [2:0] REG_BOX_Z     = 3'd3;
    localparam logic [2:0] REG_CELLS_X   = 3'd4;
    localparam logic [2:0] REG_CELLS_Y   = 3'd5;
    localparam logic [2:0] REG_CELLS_Z   = 3'd6;

    // effective grid setup seen by both halves
    typedef struct packed {
        logic [FIX_W-1:0]            cs;
        logic [2:0][FIX_W-1:0]       box;
        logic [2:0][DIM_W-1:0]       dim;
        logic [DIM_W-1:0]            dxy;
        logic [DIM_W-1:0]            nc;
    } cfg_t;

    // classified command handed from front to back
    typedef struct packed {
        kind_t                       kind;
        logic [PID_W-1:0]            slot;
        logic [CELL_W-1:0]           cell_idx;
        logic [2:0][CELL_W-1:0]      lo;
        logic [2:0][CELL_W-1:0]      hi;
    } qent_t;

    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [CELL_W-1:0] cell_idx;
        logic [CNT_W-1:0]  rb;
        logic [CNT_W-1:0]  re;
        logic [1:0]        status;
        logic              last;
    } res_t;

    function automatic logic [DIM_W-1:0] dim_fix(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
            r = DIM_W'(1);
        else if (d > MAX_DIM)
            r = MAX_DIM;
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] sat_cells(input logic [2*DIM_W-1:0] p);
        logic [DIM_W-1:0] r;
        r = (p > {{DIM_W{1'b0}}, MAX_NC}) ? MAX_NC : p[DIM_W-1:0];
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] lin_cell(input logic [CELL_W-1:0] gx,
                                                    input logic [PROD_W-1:0] py,
                                                    input logic [PROD_W-1:0] pz,
                                                    input logic [DIM_W-1:0]  nc);
        logic [PROD_W:0]    sum;
        logic [DIM_W-1:0]   ncm1;
        logic [CELL_W-1:0]  r;
        sum  = {{(PROD_W+1-CELL_W){1'b0}}, gx} + {1'b0, py} + {1'b0, pz};
        ncm1 = nc - DIM_W'(1);
        r    = (sum >= {{(PROD_W+1-DIM_W){1'b0}}, nc}) ? ncm1[CELL_W-1:0] : sum[CELL_W-1:0];
        return r;
    endfunction

endpackage

// ----- sv/ugcs_if.sv -----
// channel interfaces: item input, result output, register write
interface ugcs_in_if import ugcs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [PID_W-1:0]        slot;

    modport source (output valid, kind, pos_x, pos_y, pos_z, slot, input ready);
    modport sink   (input valid, kind, pos_x, pos_y, pos_z, slot, output ready);
endinterface

interface ugcs_out_if import ugcs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PID_W-1:0]  particle_id;
    logic [CELL_W-1:0] cell_id;
    logic [CNT_W-1:0]  range_begin;
    logic [CNT_W-1:0]  range_end;
    logic [1:0]        status;
    logic              last;

    modport source (output valid, particle_id, cell_id, range_begin, range_end, status, last,
                    input ready);
    modport sink   (input valid, particle_id, cell_id, range_begin, range_end, status, last,
                    output ready);
endinterface

interface ugcs_cfg_if import ugcs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [2:0]       index;
    logic [FIX_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/ugcs_ram.sv -----
// generic single write, single registered read memory
module ugcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/ugcs_queue.sv -----
// two-entry command queue between front and back
module ugcs_queue import ugcs_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  qent_t push_data,
    output logic  full,
    input  logic  pop,
    output qent_t head,
    output logic  empty
);
    qent_t      ent_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = ent_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                ent_reg[wr_reg] <= push_data;
                wr_reg          <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ----- sv/ugcs_front.sv -----
// front end: takes items, divides positions into grid coordinates, queues commands
module ugcs_front import ugcs_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    ugcs_in_if.sink item_in,
    input  cfg_t  cfg,
    input  logic  settled,
    output logic  push,
    output qent_t push_data,
    input  logic  full
);
    typedef enum logic [2:0] {
        F_IDLE,
        F_LOAD_DIV,
        F_DIV,
        F_SAT,
        F_MUL,
        F_SUM,
        F_PUSH
    } fstate_t;

    fstate_t                  state_reg;
    logic signed [POS_W-1:0]  pos_reg [3];
    logic [FIX_W-1:0]         dvd_reg [3];
    logic [FIX_W-1:0]         rem_reg [3];
    logic [4:0]               cnt_reg;
    logic                     pass_reg;
    qent_t                    ent_reg;
    logic [CELL_W-1:0]        g_reg [3];
    logic [PROD_W-1:0]        py_reg;
    logic [PROD_W-1:0]        pz_reg;

    logic [FIX_W:0]           trial [3];
    logic                     ge [3];
    logic [FIX_W:0]           rem_nx [3];
    logic signed [POS_W+1:0]  v [3];
    logic [FIX_W-1:0]         clamp_v [3];
    logic [DIM_W-1:0]         dm1 [3];
    logic [CELL_W-1:0]        gsat [3];
    logic signed [POS_W+1:0]  delta;

    assign item_in.ready = (state_reg == F_IDLE) && settled;
    assign push          = (state_reg == F_PUSH) && !full;
    assign push_data     = ent_reg;

    always_comb
    begin
        if (pass_reg)
            delta = $signed({3'b000, cfg.cs});
        else if (ent_reg.kind == KIND_QUERY)
            delta = -$signed({3'b000, cfg.cs});
        else
            delta = '0;
        for (int a = 0; a < 3; a++)
        begin
            trial[a]  = {rem_reg[a], dvd_reg[a][FIX_W-1]};
            ge[a]     = trial[a] >= {1'b0, cfg.cs};
            rem_nx[a] = ge[a] ? (trial[a] - {1'b0, cfg.cs}) : trial[a];
            v[a]      = $signed({{2{pos_reg[a][POS_W-1]}}, pos_reg[a]}) + delta;
            if (v[a][POS_W+1])
                clamp_v[a] = '0;
            else if (v[a] > $signed({3'b000, cfg.box[a]}))
                clamp_v[a] = cfg.box[a];
            else
                clamp_v[a] = v[a][FIX_W-1:0];
            dm1[a]  = cfg.dim[a] - DIM_W'(1);
            gsat[a] = (dvd_reg[a] > {{(FIX_W-DIM_W){1'b0}}, dm1[a]})
                      ? dm1[a][CELL_W-1:0] : dvd_reg[a][CELL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            pass_reg  <= 1'b0;
            ent_reg   <= '0;
            py_reg    <= '0;
            pz_reg    <= '0;
            for (int a = 0; a < 3; a++)
            begin
                pos_reg[a] <= '0;
                dvd_reg[a] <= '0;
                rem_reg[a] <= '0;
                g_reg[a]   <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (item_in.valid && item_in.ready)
                    begin
                        ent_reg      <= '{kind: kind_t'(item_in.kind), slot: item_in.slot,
                                          cell_idx: '0, lo: '0, hi: '0};
                        pos_reg[0]   <= item_in.pos_x;
                        pos_reg[1]   <= item_in.pos_y;
                        pos_reg[2]   <= item_in.pos_z;
                        pass_reg     <= 1'b0;
                        if (kind_t'(item_in.kind) == KIND_LOAD ||
                            kind_t'(item_in.kind) == KIND_QUERY)
                            state_reg <= F_LOAD_DIV;
                        else
                            state_reg <= F_PUSH;
                    end
                end
                F_LOAD_DIV:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        dvd_reg[a] <= clamp_v[a];
                        rem_reg[a] <= '0;
                    end
                    cnt_reg   <= '0;
                    state_reg <= F_DIV;
                end
                F_DIV:
                begin
                    // one restoring quotient bit per lane per cycle
                    for (int a = 0; a < 3; a++)
                    begin
                        rem_reg[a] <= rem_nx[a][FIX_W-1:0];
                        dvd_reg[a] <= {dvd_reg[a][FIX_W-2:0], ge[a]};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(DIV_STEPS - 1))
                        state_reg <= F_SAT;
                end
                F_SAT:
                begin
                    if (ent_reg.kind == KIND_LOAD)
                    begin
                        for (int a = 0; a < 3; a++)
                            g_reg[a] <= gsat[a];
                        state_reg <= F_MUL;
                    end
                    else if (!pass_reg)
                    begin
                        for (int a = 0; a < 3; a++)
                            ent_reg.lo[a] <= gsat[a];
                        pass_reg  <= 1'b1;
                        state_reg <= F_LOAD_DIV;
                    end
                    else
                    begin
                        for (int a = 0; a < 3; a++)
                            ent_reg.hi[a] <= gsat[a];
                        state_reg <= F_PUSH;
                    end
                end
                F_MUL:
                begin
                    py_reg    <= g_reg[1] * cfg.dim[0];
                    pz_reg    <= g_reg[2] * cfg.dxy;
                    state_reg <= F_SUM;
                end
                F_SUM:
                begin
                    ent_reg.cell_idx <= lin_cell(g_reg[0], py_reg, pz_reg, cfg.nc);
                    state_reg        <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!full)
                        state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- sv/ugcs_back.sv -----
// back end: particle store, counting sort, slot reads and neighbor range walks
module ugcs_back import ugcs_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  cfg_hit,
    input  qent_t head,
    input  logic  empty,
    output logic  pop,
    ugcs_out_if.source result_out
);
    typedef enum logic [4:0] {
        B_IDLE, B_DISP, B_EMIT,
        S_CLR, S_CNT_RD, S_CNT_C, S_CNT_W, S_PFX_RD, S_PFX_W, S_PFX_END,
        P_RD_I, P_LAT, P_RD_C, P_CHK, P_SW1, P_SW2, P_SW3,
        R_PID, R_CELL,
        Q_MUL, Q_SUM, Q_B, Q_E
    } bstate_t;

    bstate_t            state_reg;
    bstate_t            ret_reg;
    qent_t              cmd_reg;
    logic [CNT_W-1:0]   lc_reg;
    logic               sorted_reg;
    logic [OFF_AW-1:0]  idx_reg;
    logic [CNT_W-1:0]   run_reg;
    logic [CELL_W-1:0]  c_reg;
    logic [PID_W-1:0]   j_reg;
    logic [PID_W-1:0]   sp_i_reg;
    logic [CNT_W-1:0]   off_reg;
    logic [CELL_W-1:0]  x_reg, y_reg, z_reg;
    logic [PROD_W-1:0]  py_reg, pz_reg;
    res_t               res_reg;
    res_t               out_reg;
    logic               out_valid_reg;

    logic               pc_we;
    logic [PID_W-1:0]   pc_waddr, pc_raddr;
    logic [CELL_W-1:0]  pc_wdata, pc_rd;
    logic               cur_we;
    logic [CELL_W-1:0]  cur_waddr, cur_raddr;
    logic [CNT_W-1:0]   cur_wdata, cur_rd;
    logic               off_we;
    logic [OFF_AW-1:0]  off_waddr, off_raddr;
    logic [CNT_W-1:0]   off_wdata, off_rd;
    logic               wc_we;
    logic [PID_W-1:0]   wc_waddr, wc_raddr;
    logic [CELL_W-1:0]  wc_wdata, wc_rd;
    logic               sp_we;
    logic [PID_W-1:0]   sp_waddr, sp_raddr;
    logic [PID_W-1:0]   sp_wdata, sp_rd;

    logic [DIM_W-1:0]   ncm1;
    logic [CELL_W-1:0]  pc_clamped;
    logic [CELL_W-1:0]  q_cell;
    logic               in_run;
    logic               q_last;

    ugcs_ram #(.WIDTH(CELL_W), .DEPTH(MAX_PARTICLES)) u_particle_cell (
        .clk(clk), .we(pc_we), .waddr(pc_waddr), .wdata(pc_wdata),
        .raddr(pc_raddr), .rdata(pc_rd));
    ugcs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CELLS)) u_cell_cursor (
        .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
        .raddr(cur_raddr), .rdata(cur_rd));
    ugcs_ram #(.WIDTH(CNT_W), .DEPTH(OFF_DEPTH)) u_cell_offset (
        .clk(clk), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
        .raddr(off_raddr), .rdata(off_rd));
    ugcs_ram #(.WIDTH(CELL_W), .DEPTH(MAX_PARTICLES)) u_work_cell (
        .clk(clk), .we(wc_we), .waddr(wc_waddr), .wdata(wc_wdata),
        .raddr(wc_raddr), .rdata(wc_rd));
    ugcs_ram #(.WIDTH(PID_W), .DEPTH(MAX_PARTICLES)) u_slot_particle (
        .clk(clk), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
        .raddr(sp_raddr), .rdata(sp_rd));

    assign result_out.valid       = out_valid_reg;
    assign result_out.particle_id = out_reg.pid;
    assign result_out.cell_id     = out_reg.cell_idx;
    assign result_out.range_begin = out_reg.rb;
    assign result_out.range_end   = out_reg.re;
    assign result_out.status      = out_reg.status;
    assign result_out.last        = out_reg.last;

    assign ncm1       = cfg.nc - DIM_W'(1);
    assign pc_clamped = ({1'b0, pc_rd} >= cfg.nc) ? ncm1[CELL_W-1:0] : pc_rd;
    assign q_cell     = lin_cell(x_reg, py_reg, pz_reg, cfg.nc);
    assign in_run     = (idx_reg >= {2'b00, off_rd}) && (idx_reg < {2'b00, cur_rd});
    assign q_last     = (x_reg == cmd_reg.hi[0]) && (y_reg == cmd_reg.hi[1]) &&
                        (z_reg == cmd_reg.hi[2]);
    assign pop        = (state_reg == B_IDLE) && !empty;

    // memory port steering
    always_comb
    begin
        pc_we = 1'b0;  pc_waddr = '0;  pc_wdata = '0;  pc_raddr = '0;
        cur_we = 1'b0; cur_waddr = '0; cur_wdata = '0; cur_raddr = '0;
        off_we = 1'b0; off_waddr = '0; off_wdata = '0; off_raddr = '0;
        wc_we = 1'b0;  wc_waddr = '0;  wc_wdata = '0;  wc_raddr = '0;
        sp_we = 1'b0;  sp_waddr = '0;  sp_wdata = '0;  sp_raddr = '0;
        unique case (state_reg)
            B_DISP:
            begin
                pc_waddr = lc_reg[PID_W-1:0];
                pc_wdata = cmd_reg.cell_idx;
                pc_we    = (cmd_reg.kind == KIND_LOAD) && (lc_reg < MAX_PART_CNT);
                sp_raddr = cmd_reg.slot;
            end
            S_CLR:
            begin
                cur_we    = 1'b1;
                cur_waddr = idx_reg[CELL_W-1:0];
            end
            S_CNT_RD:
            begin
                pc_raddr = idx_reg[PID_W-1:0];
            end
            S_CNT_C:
            begin
                wc_we     = 1'b1;
                wc_waddr  = idx_reg[PID_W-1:0];
                wc_wdata  = pc_clamped;
                sp_we     = 1'b1;
                sp_waddr  = idx_reg[PID_W-1:0];
                sp_wdata  = idx_reg[PID_W-1:0];
                cur_raddr = pc_clamped;
            end
            S_CNT_W:
            begin
                cur_we    = 1'b1;
                cur_waddr = c_reg;
                cur_wdata = cur_rd + CNT_W'(1);
            end
            S_PFX_RD:
            begin
                cur_raddr = idx_reg[CELL_W-1:0];
            end
            S_PFX_W:
            begin
                off_we    = 1'b1;
                off_waddr = idx_reg;
                off_wdata = run_reg;
                cur_we    = 1'b1;
                cur_waddr = idx_reg[CELL_W-1:0];
                cur_wdata = run_reg;
            end
            S_PFX_END:
            begin
                off_we    = 1'b1;
                off_waddr = cfg.nc;
                off_wdata = run_reg;
            end
            P_RD_I:
            begin
                wc_raddr = idx_reg[PID_W-1:0];
                sp_raddr = idx_reg[PID_W-1:0];
            end
            P_RD_C:
            begin
                off_raddr = {1'b0, c_reg};
                cur_raddr = c_reg;
            end
            P_CHK:
            begin
                cur_we    = !in_run;
                cur_waddr = c_reg;
                cur_wdata = cur_rd + CNT_W'(1);
            end
            P_SW1:
            begin
                wc_raddr = j_reg;
                sp_raddr = j_reg;
            end
            P_SW2:
            begin
                wc_we    = 1'b1;
                wc_waddr = j_reg;
                wc_wdata = c_reg;
                sp_we    = 1'b1;
                sp_waddr = j_reg;
                sp_wdata = sp_i_reg;
            end
            P_SW3:
            begin
                wc_we    = 1'b1;
                wc_waddr = idx_reg[PID_W-1:0];
                wc_wdata = c_reg;
                sp_we    = 1'b1;
                sp_waddr = idx_reg[PID_W-1:0];
                sp_wdata = sp_i_reg;
            end
            R_PID:
            begin
                pc_raddr = sp_rd;
            end
            Q_SUM:
            begin
                off_raddr = {1'b0, q_cell};
            end
            Q_B:
            begin
                off_raddr = {1'b0, c_reg} + OFF_AW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            ret_reg       <= B_IDLE;
            cmd_reg       <= '0;
            lc_reg        <= '0;
            sorted_reg    <= 1'b0;
            idx_reg       <= '0;
            run_reg       <= '0;
            c_reg         <= '0;
            j_reg         <= '0;
            sp_i_reg      <= '0;
            off_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            py_reg        <= '0;
            pz_reg        <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (result_out.ready && state_reg != B_EMIT)
                out_valid_reg <= 1'b0;
            if (cfg_hit)
                sorted_reg <= 1'b0;

            unique case (state_reg)
                B_IDLE:
                begin
                    if (!empty)
                    begin
                        cmd_reg   <= head;
                        state_reg <= B_DISP;
                    end
                end
                B_DISP:
                begin
                    ret_reg <= B_IDLE;
                    unique case (cmd_reg.kind)
                        KIND_LOAD:
                        begin
                            sorted_reg <= 1'b0;
                            if (lc_reg < MAX_PART_CNT)
                            begin
                                res_reg <= '{pid: lc_reg[PID_W-1:0],
                                             cell_idx: cmd_reg.cell_idx,
                                             rb: '0, re: '0, status: ST_OK, last: 1'b1};
                                lc_reg  <= lc_reg + CNT_W'(1);
                            end
                            else
                            begin
                                res_reg <= '{pid: '0, cell_idx: '0, rb: '0, re: '0,
                                             status: ST_FULL, last: 1'b1};
                            end
                            state_reg <= B_EMIT;
                        end
                        KIND_SORT:
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_CLR;
                        end
                        KIND_READ:
                        begin
                            if (!sorted_reg || ({1'b0, cmd_reg.slot} >= lc_reg))
                            begin
                                res_reg <= '{pid: '0, cell_idx: '0, rb: '0, re: '0,
                                             status: ST_NOSORT, last: 1'b1};
                                state_reg <= B_EMIT;
                            end
                            else
                            begin
                                state_reg <= R_PID;
                            end
                        end
                        KIND_QUERY:
                        begin
                            if (!sorted_reg)
                            begin
                                res_reg <= '{pid: '0, cell_idx: '0, rb: '0, re: '0,
                                             status: ST_NOSORT, last: 1'b1};
                                state_reg <= B_EMIT;
                            end
                            else
                            begin
                                x_reg     <= cmd_reg.lo[0];
                                y_reg     <= cmd_reg.lo[1];
                                z_reg     <= cmd_reg.lo[2];
                                state_reg <= Q_MUL;
                            end
                        end
                        default:
                        begin
                            state_reg <= B_IDLE;
                        end
                    endcase
                end
                B_EMIT:
                begin
                    if (!out_valid_reg || result_out.ready)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ret_reg;
                    end
                end
                S_CLR:
                begin
                    if (idx_reg == ncm1)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_CNT_RD;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + OFF_AW'(1);
                    end
                end
                S_CNT_RD:
                begin
                    if (idx_reg == {2'b00, lc_reg})
                    begin
                        idx_reg   <= '0;
                        run_reg   <= '0;
                        state_reg <= S_PFX_RD;
                    end
                    else
                    begin
                        state_reg <= S_CNT_C;
                    end
                end
                S_CNT_C:
                begin
                    c_reg     <= pc_clamped;
                    state_reg <= S_CNT_W;
                end
                S_CNT_W:
                begin
                    idx_reg   <= idx_reg + OFF_AW'(1);
                    state_reg <= S_CNT_RD;
                end
                S_PFX_RD:
                begin
                    state_reg <= S_PFX_W;
                end
                S_PFX_W:
                begin
                    run_reg <= run_reg + cur_rd;
                    if (idx_reg == ncm1)
                    begin
                        state_reg <= S_PFX_END;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + OFF_AW'(1);
                        state_reg <= S_PFX_RD;
                    end
                end
                S_PFX_END:
                begin
                    idx_reg   <= '0;
                    state_reg <= P_RD_I;
                end
                P_RD_I:
                begin
                    if (idx_reg == {2'b00, lc_reg})
                    begin
                        sorted_reg <= 1'b1;
                        res_reg    <= '{pid: '0, cell_idx: '0, rb: '0, re: lc_reg,
                                        status: ST_OK, last: 1'b1};
                        state_reg  <= B_EMIT;
                    end
                    else
                    begin
                        state_reg <= P_LAT;
                    end
                end
                P_LAT:
                begin
                    c_reg     <= wc_rd;
                    sp_i_reg  <= sp_rd;
                    state_reg <= P_RD_C;
                end
                P_RD_C:
                begin
                    state_reg <= P_CHK;
                end
                P_CHK:
                begin
                    // particle already inside its cell's placed run, or no slot left
                    if (in_run || (cur_rd >= lc_reg))
                    begin
                        idx_reg   <= idx_reg + OFF_AW'(1);
                        state_reg <= P_RD_I;
                    end
                    else
                    begin
                        j_reg     <= cur_rd[PID_W-1:0];
                        state_reg <= P_SW1;
                    end
                end
                P_SW1:
                begin
                    state_reg <= P_SW2;
                end
                P_SW2:
                begin
                    c_reg     <= wc_rd;
                    sp_i_reg  <= sp_rd;
                    state_reg <= P_SW3;
                end
                P_SW3:
                begin
                    state_reg <= P_RD_C;
                end
                R_PID:
                begin
                    sp_i_reg  <= sp_rd;
                    state_reg <= R_CELL;
                end
                R_CELL:
                begin
                    res_reg   <= '{pid: sp_i_reg, cell_idx: pc_clamped, rb: '0, re: '0,
                                   status: ST_OK, last: 1'b1};
                    state_reg <= B_EMIT;
                end
                Q_MUL:
                begin
                    py_reg    <= y_reg * cfg.dim[0];
                    pz_reg    <= z_reg * cfg.dxy;
                    state_reg <= Q_SUM;
                end
                Q_SUM:
                begin
                    c_reg     <= q_cell;
                    state_reg <= Q_B;
                end
                Q_B:
                begin
                    off_reg   <= off_rd;
                    state_reg <= Q_E;
                end
                Q_E:
                begin
                    res_reg <= '{pid: '0, cell_idx: c_reg, rb: off_reg, re: off_rd,
                                 status: ST_OK, last: q_last};
                    ret_reg <= q_last ? B_IDLE : Q_MUL;
                    if (x_reg != cmd_reg.hi[0])
                    begin
                        x_reg <= x_reg + CELL_W'(1);
                    end
                    else
                    begin
                        x_reg <= cmd_reg.lo[0];
                        if (y_reg != cmd_reg.hi[1])
                        begin
                            y_reg <= y_reg + CELL_W'(1);
                        end
                        else
                        begin
                            y_reg <= cmd_reg.lo[1];
                            z_reg <= z_reg + CELL_W'(1);
                        end
                    end
                    state_reg <= B_EMIT;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- sv/uniform_grid_cell_sort_and_query.sv -----
// top level: uniform grid cell sort and neighbor range query
// Particles are loaded in signed Q16.16, clamped per axis to the box and divided by
// the cell size into a linear cell index; a sort command builds per-cell offsets and
// the sorted slot order, read commands return the particle at a slot and query
// commands return the slot ranges of the clamped 3x3x3 neighborhood, x fastest.
// Item steps: a load runs three restoring dividers side by side over the 31-bit
// dividend, one quotient bit per cycle, then multiply, sum, queue and dispatch; a
// query runs two division passes, then per reported cell one multiply, one
// add/compare, two reads of the single offset memory read port and the hand-off to
// the result register; a sort's time is set by the cell and particle memories it
// sweeps, each with a single read port. The front divides the next item while the
// back still works, through a two-entry command queue, and a result register lets
// the back go on while a result waits to be taken.
// After a register write the input stays not ready while the derived cell counts
// settle. Register writes are taken at any time on their own channel.
module uniform_grid_cell_sort_and_query import ugcs_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    ugcs_in_if.sink      item_in,
    ugcs_out_if.source   result_out,
    ugcs_cfg_if.sink     cfg
);
    // configuration registers
    logic [FIX_W-1:0] cell_size_reg;
    logic [FIX_W-1:0] box_reg [3];
    logic [DIM_W-1:0] cells_reg [3];

    // derived grid sizes, one multiply per register stage
    logic [DIM_W-1:0] dxy_reg;
    logic [DIM_W-1:0] nc_reg;
    logic [1:0]       settle_reg;

    logic             cfg_hit;
    cfg_t             grid;
    logic [DIM_W-1:0] dim [3];

    logic             push;
    logic             full;
    logic             pop;
    logic             empty;
    qent_t            push_data;
    qent_t            head;

    assign cfg.ready = 1'b1;
    // any known register index invalidates the sort
    assign cfg_hit = cfg.valid && (cfg.index <= REG_CELLS_Z);

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            dim[a]        = dim_fix(cells_reg[a]);
            grid.box[a]   = box_reg[a];
            grid.dim[a]   = dim[a];
        end
        // a zero cell size acts as one LSB (1/65536 in Q16.16)
        grid.cs  = (cell_size_reg == '0) ? FIX_W'(1) : cell_size_reg;
        grid.dxy = dxy_reg;
        grid.nc  = nc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg <= FIX_W'(65536);
            for (int a = 0; a < 3; a++)
            begin
                box_reg[a]   <= FIX_W'(1048576);
                cells_reg[a] <= DIM_W'(16);
            end
            dxy_reg    <= DIM_W'(256);
            nc_reg     <= MAX_NC;
            settle_reg <= 2'd0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_CELL_SIZE: cell_size_reg <= cfg.data;
                    REG_BOX_X:     box_reg[0]    <= cfg.data;
                    REG_BOX_Y:     box_reg[1]    <= cfg.data;
                    REG_BOX_Z:     box_reg[2]    <= cfg.data;
                    REG_CELLS_X:   cells_reg[0]  <= cfg.data[DIM_W-1:0];
                    REG_CELLS_Y:   cells_reg[1]  <= cfg.data[DIM_W-1:0];
                    REG_CELLS_Z:   cells_reg[2]  <= cfg.data[DIM_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            // saturated cell counts: dxy from the x and y counts, then nc from dxy and z
            dxy_reg <= sat_cells(dim[0] * dim[1]);
            nc_reg  <= sat_cells(dxy_reg * dim[2]);
            if (cfg.valid)
                settle_reg <= 2'd3;
            else if (settle_reg != 2'd0)
                settle_reg <= settle_reg - 2'd1;
        end
    end

    // front: accepts items and computes grid coordinates
    ugcs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_in),
        .cfg       (grid),
        .settled   (settle_reg == 2'd0 && !cfg.valid),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // command queue decoupling front and back
    ugcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    // back: memories, sort sequencer and result register
    ugcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (grid),
        .cfg_hit    (cfg_hit),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .result_out (result_out)
    );
endmodule
